[design/triangle_tangent_bitangent_core_macros.svh]
// Assertion macros for the triangle tangent/bitangent core.
// Used by the top level; expects clk and rst in scope.
`ifndef TRIANGLE_TANGENT_BITANGENT_CORE_MACROS_SVH
`define TRIANGLE_TANGENT_BITANGENT_CORE_MACROS_SVH

// same-cycle implication
`define TTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ttb_pkg.sv]
// Shared types and constants of the triangle tangent/bitangent core.
// No dependencies.
`default_nettype none
package ttb_pkg;
  // the largest normalized magnitude lies in [2^29, 2^30)
  localparam int NORM_BITS = 30;
  // sum of three squares and square-root work registers
  localparam int ROOT_WORK_BITS = 63;
  localparam int ROOT_BITS = 31;
  localparam logic [1:0] LAST_CORNER = 2'd2;

  typedef enum logic [1:0] {PH_C0, PH_C1, PH_C2, PH_BAD} phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SUB, ST_NORM, ST_SQ, ST_ROOT,
    ST_DIV_LOAD, ST_DIV, ST_STORE, ST_EMIT
  } back_state_t;
endpackage
`default_nettype wire

[design/ttb_front.sv]
// Front end: accepts vertices, tracks the corner phase, holds corners 0 and 1,
// and forms edges and texture deltas on the third corner. Uses ttb_pkg.
`default_nettype none
module ttb_front #(
  parameter int COORD_BITS = 16,
  parameter int UV_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [COORD_BITS-1:0] pos_x,
  input  wire logic signed [COORD_BITS-1:0] pos_y,
  input  wire logic signed [COORD_BITS-1:0] pos_z,
  input  wire logic signed [UV_BITS-1:0] tex_u,
  input  wire logic signed [UV_BITS-1:0] tex_v,
  input  wire logic start_of_mesh,
  input  wire logic full,
  output logic push,
  output logic [6*((COORD_BITS+1 > 25) ? 25 : COORD_BITS+1)
                + 4*((UV_BITS+1 > 25) ? 25 : UV_BITS+1)-1:0] job
);
  localparam int EW0 = COORD_BITS + 1;
  localparam int ESH = (EW0 > 25) ? COORD_BITS - 24 : 0;
  localparam int EW = EW0 - ESH;
  localparam int DW0 = UV_BITS + 1;
  localparam int DSH = (DW0 > 25) ? UV_BITS - 24 : 0;
  localparam int DW = DW0 - DSH;

  ttb_pkg::phase_t phase;
  ttb_pkg::phase_t ph;
  logic fire;
  logic signed [COORD_BITS-1:0] hp [2][3];
  logic signed [UV_BITS-1:0] ht [2][2];
  logic signed [COORD_BITS-1:0] cur_p [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [DW-1:0] du1, dv1, du2, dv2;

  function automatic logic signed [EW-1:0] shrink_e(input logic signed [EW0-1:0] x);
    logic [EW0-1:0] m;
    logic [EW0-1:0] s;
    m = x[EW0-1] ? EW0'(-x) : EW0'(x);
    s = m >> ESH;
    shrink_e = x[EW0-1] ? EW'(-s) : EW'(s);
  endfunction

  function automatic logic signed [DW-1:0] shrink_d(input logic signed [DW0-1:0] x);
    logic [DW0-1:0] m;
    logic [DW0-1:0] s;
    m = x[DW0-1] ? DW0'(-x) : DW0'(x);
    s = m >> DSH;
    shrink_d = x[DW0-1] ? DW'(-s) : DW'(s);
  endfunction

  function automatic logic signed [EW0-1:0] pdiff(input logic signed [COORD_BITS-1:0] a,
                                                  input logic signed [COORD_BITS-1:0] b);
    pdiff = EW0'(a) - EW0'(b);
  endfunction

  function automatic logic signed [DW0-1:0] tdiff(input logic signed [UV_BITS-1:0] a,
                                                  input logic signed [UV_BITS-1:0] b);
    tdiff = DW0'(a) - DW0'(b);
  endfunction

  // start flag or the unused code restarts at corner 0
  assign ph = (start_of_mesh || phase == ttb_pkg::PH_BAD) ? ttb_pkg::PH_C0 : phase;
  assign in_ready = !(ph == ttb_pkg::PH_C2 && full);
  assign fire = in_valid && in_ready;
  assign push = fire && ph == ttb_pkg::PH_C2;

  assign cur_p[0] = pos_x;
  assign cur_p[1] = pos_y;
  assign cur_p[2] = pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = shrink_e(pdiff(hp[1][i], hp[0][i]));
      e2[i] = shrink_e(pdiff(cur_p[i], hp[0][i]));
    end
    du1 = shrink_d(tdiff(ht[1][0], ht[0][0]));
    dv1 = shrink_d(tdiff(ht[1][1], ht[0][1]));
    du2 = shrink_d(tdiff(tex_u, ht[0][0]));
    dv2 = shrink_d(tdiff(tex_v, ht[0][1]));
  end

  assign job = {e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], du1, dv1, du2, dv2};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ttb_pkg::PH_C0;
    end else if (fire) begin
      case (ph)
        ttb_pkg::PH_C0: phase <= ttb_pkg::PH_C1;
        ttb_pkg::PH_C1: phase <= ttb_pkg::PH_C2;
        default:        phase <= ttb_pkg::PH_C0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ph != ttb_pkg::PH_C2) begin
      hp[ph[0]][0] <= pos_x;
      hp[ph[0]][1] <= pos_y;
      hp[ph[0]][2] <= pos_z;
      ht[ph[0]][0] <= tex_u;
      ht[ph[0]][1] <= tex_v;
    end
  end
endmodule
`default_nettype wire

[design/ttb_queue.sv]
// Two-entry request queue between front and back end.
// No dependencies.
`default_nettype none
module ttb_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic pop,
  output logic [WIDTH-1:0] dout,
  output logic not_empty,
  output logic full
);
  logic [WIDTH-1:0] mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign dout = mem[rd_ptr];
  assign not_empty = count != 2'd0;
  assign full = count == 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end
endmodule
`default_nettype wire

[design/ttb_back.sv]
// Back end: cross products, normalization (shift, sum of squares, bit-serial
// square root and division) and three-corner output. Uses ttb_pkg.
`default_nettype none
module ttb_back #(
  parameter int COORD_BITS = 16,
  parameter int UV_BITS = 16,
  parameter int OUT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire logic [6*((COORD_BITS+1 > 25) ? 25 : COORD_BITS+1)
                     + 4*((UV_BITS+1 > 25) ? 25 : UV_BITS+1)-1:0] job,
  output logic pop,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [OUT_BITS-1:0] tangent_x,
  output logic signed [OUT_BITS-1:0] tangent_y,
  output logic signed [OUT_BITS-1:0] tangent_z,
  output logic signed [OUT_BITS-1:0] bitangent_x,
  output logic signed [OUT_BITS-1:0] bitangent_y,
  output logic signed [OUT_BITS-1:0] bitangent_z,
  output logic [1:0] corner_index,
  output logic last_of_triangle
);
  localparam int EW = (COORD_BITS + 1 > 25) ? 25 : COORD_BITS + 1;
  localparam int DW = (UV_BITS + 1 > 25) ? 25 : UV_BITS + 1;
  localparam int PW = EW + DW;
  localparam int VW = PW + 1;
  localparam int RW = (VW > 31) ? VW : 31;
  localparam int NB = ttb_pkg::NORM_BITS;
  localparam int SW = ttb_pkg::ROOT_WORK_BITS;
  localparam int LB = ttb_pkg::ROOT_BITS;
  localparam int QB = OUT_BITS - 1;
  localparam int NW = OUT_BITS + NB;
  localparam int CW = $clog2(QB);

  ttb_pkg::back_state_t state, state_next;

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [DW-1:0] du1, dv1, du2, dv2;
  logic vec;
  logic [1:0] cnt;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [EW-1:0] mul_x, mul_y;
  logic signed [VW-1:0] comp;
  logic [VW-1:0] comp_mag;
  logic [RW-1:0] mg [3];
  logic sg [3];
  logic [RW-1:0] mx01, mx;
  logic [2*NB-1:0] sq_p;
  logic [SW-1:0] acc, rn, rr, rbit, rtry;
  logic [LB-1:0] len;
  logic [NB-1:0] cur_m;
  logic [NW-1:0] numer;
  logic [LB+1:0] drem, dtry, dden;
  logic [QB-1:0] nlo, q;
  logic [CW-1:0] dcnt;
  logic [OUT_BITS-1:0] q_ext, q_signed;
  logic signed [OUT_BITS-1:0] res_t [3];
  logic signed [OUT_BITS-1:0] res_b [3];
  logic [1:0] corner;
  logic vec_done;

  // operand selection: tangent = dV2*E1 - dV1*E2, bitangent = dU1*E2 - dU2*E1
  assign mul_a = vec ? du1 : dv2;
  assign mul_b = vec ? du2 : dv1;
  assign mul_x = vec ? e2[cnt] : e1[cnt];
  assign mul_y = vec ? e1[cnt] : e2[cnt];
  assign comp = VW'(prod_a) - VW'(prod_b);
  assign comp_mag = comp[VW-1] ? VW'(-comp) : VW'(comp);

  assign mx01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
  assign mx = (mx01 > mg[2]) ? mx01 : mg[2];

  assign rtry = rr + rbit;
  assign len = rr[LB-1:0];
  assign cur_m = mg[cnt][NB-1:0];
  assign numer = {cur_m, {QB{1'b0}}} + NW'(len);
  assign dden = {1'b0, len, 1'b0};
  assign dtry = {drem[LB:0], nlo[QB-1]};
  assign q_ext = OUT_BITS'(q);
  assign q_signed = sg[cnt] ? OUT_BITS'(-q_ext) : q_ext;
  assign vec_done = (state == ttb_pkg::ST_STORE && cnt == 2'd2)
                 || (state == ttb_pkg::ST_NORM && mx == '0);

  always_ff @(posedge clk) begin
    if (rst) state <= ttb_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    out_valid = 1'b0;
    case (state)
      ttb_pkg::ST_IDLE: begin
        if (job_valid) begin
          pop = 1'b1;
          state_next = ttb_pkg::ST_MUL;
        end
      end
      ttb_pkg::ST_MUL: state_next = ttb_pkg::ST_SUB;
      ttb_pkg::ST_SUB: state_next = (cnt == 2'd2) ? ttb_pkg::ST_NORM : ttb_pkg::ST_MUL;
      ttb_pkg::ST_NORM: begin
        if (mx == '0) state_next = vec ? ttb_pkg::ST_EMIT : ttb_pkg::ST_MUL;
        else if (!(|mx[RW-1:NB]) && mx[NB-1]) state_next = ttb_pkg::ST_SQ;
      end
      ttb_pkg::ST_SQ: if (cnt == 2'd3) state_next = ttb_pkg::ST_ROOT;
      ttb_pkg::ST_ROOT: if (rbit[0]) state_next = ttb_pkg::ST_DIV_LOAD;
      ttb_pkg::ST_DIV_LOAD: state_next = ttb_pkg::ST_DIV;
      ttb_pkg::ST_DIV: if (dcnt == CW'(QB - 1)) state_next = ttb_pkg::ST_STORE;
      ttb_pkg::ST_STORE: begin
        if (cnt != 2'd2) state_next = ttb_pkg::ST_DIV_LOAD;
        else state_next = vec ? ttb_pkg::ST_EMIT : ttb_pkg::ST_MUL;
      end
      ttb_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && corner == ttb_pkg::LAST_CORNER) state_next = ttb_pkg::ST_IDLE;
      end
      default: state_next = ttb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= 2'd0;
    end else if (state == ttb_pkg::ST_EMIT && out_ready) begin
      corner <= (corner == ttb_pkg::LAST_CORNER) ? 2'd0 : corner + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ttb_pkg::ST_IDLE: begin
        {e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], du1, dv1, du2, dv2} <= job;
        vec <= 1'b0;
        cnt <= 2'd0;
      end
      ttb_pkg::ST_MUL: begin
        prod_a <= mul_a * mul_x;
        prod_b <= mul_b * mul_y;
      end
      ttb_pkg::ST_SUB: begin
        sg[cnt] <= comp[VW-1];
        mg[cnt] <= RW'(comp_mag);
        cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
      end
      ttb_pkg::ST_NORM: begin
        acc <= '0;
        sq_p <= '0;
        if (mx == '0) begin
          for (int i = 0; i < 3; i++) begin
            if (vec) res_b[i] <= '0;
            else res_t[i] <= '0;
          end
        end else if (|mx[RW-1:NB]) begin
          for (int i = 0; i < 3; i++) mg[i] <= mg[i] >> 1;
        end else if (!mx[NB-1]) begin
          for (int i = 0; i < 3; i++) mg[i] <= mg[i] << 1;
        end
      end
      ttb_pkg::ST_SQ: begin
        // one square per cycle, accumulated in the cycle after
        if (cnt != 2'd3) sq_p <= cur_m * cur_m;
        acc <= acc + SW'(sq_p);
        cnt <= cnt + 2'd1;
        rn <= acc + SW'(sq_p);
        rr <= '0;
        rbit <= SW'(1) << (SW - 1);
      end
      ttb_pkg::ST_ROOT: begin
        if (rn >= rtry) begin
          rn <= rn - rtry;
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        rbit <= rbit >> 2;
        cnt <= 2'd0;
      end
      ttb_pkg::ST_DIV_LOAD: begin
        drem <= (LB + 2)'(numer[NW-1:QB]);
        nlo <= numer[QB-1:0];
        q <= '0;
        dcnt <= '0;
      end
      ttb_pkg::ST_DIV: begin
        if (dtry >= dden) begin
          drem <= dtry - dden;
          q <= {q[QB-2:0], 1'b1};
        end else begin
          drem <= dtry;
          q <= {q[QB-2:0], 1'b0};
        end
        nlo <= nlo << 1;
        dcnt <= dcnt + CW'(1);
      end
      ttb_pkg::ST_STORE: begin
        if (vec) res_b[cnt] <= q_signed;
        else res_t[cnt] <= q_signed;
        // the last component wraps the count below
        if (cnt != 2'd2) cnt <= cnt + 2'd1;
      end
      default: ;
    endcase
    // advance to the bitangent once the tangent is stored or found to be zero
    if (vec_done) begin
      vec <= 1'b1;
      cnt <= 2'd0;
    end
  end

  assign tangent_x = res_t[0];
  assign tangent_y = res_t[1];
  assign tangent_z = res_t[2];
  assign bitangent_x = res_b[0];
  assign bitangent_y = res_b[1];
  assign bitangent_z = res_b[2];
  assign corner_index = corner;
  assign last_of_triangle = corner == ttb_pkg::LAST_CORNER;
endmodule
`default_nettype wire

[design/triangle_tangent_bitangent_core.sv]
// Triangle tangent/bitangent core.
//
// Input channel (in_valid/in_ready): one vertex per request, Q8.8 position
// and Q4.12 texture coordinate; three vertices form a triangle, and
// start_of_mesh makes the vertex corner 0 of a new triangle (a partial
// triangle before it is dropped, a trailing one gives nothing).
// Output channel (out_valid/out_ready): three requests per triangle with the
// same Q1.14 unit tangent and bitangent, corner_index 0..2, last_of_triangle
// on the third.
// Vertices 0 and 1 are taken one per cycle. Vertex 2 pushes a request into a
// two-entry queue. For the tangent, then the bitangent, the back end forms
// the cross products, shifts to normalize, sums the squares, takes a
// bit-serial square root and divides each component bit-serially; most of
// the time goes to the square root and divider. Only after the three results
// are taken does it take a new request; up to two triangles queue ahead
// while the back end works or the receiver stalls. A stalled receiver holds
// the result; once the queue is full the third vertex of the next triangle
// waits. Reset clears phase, queue and back end.
// Depends on ttb_pkg, ttb_front, ttb_queue, ttb_back and the macro header.
`default_nettype none
`include "triangle_tangent_bitangent_core_macros.svh"
module triangle_tangent_bitangent_core #(
  parameter int COORD_BITS = 16,
  parameter int UV_BITS = 16,
  parameter int OUT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [COORD_BITS-1:0] pos_x,
  input  wire logic signed [COORD_BITS-1:0] pos_y,
  input  wire logic signed [COORD_BITS-1:0] pos_z,
  input  wire logic signed [UV_BITS-1:0] tex_u,
  input  wire logic signed [UV_BITS-1:0] tex_v,
  input  wire logic start_of_mesh,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [OUT_BITS-1:0] tangent_x,
  output logic signed [OUT_BITS-1:0] tangent_y,
  output logic signed [OUT_BITS-1:0] tangent_z,
  output logic signed [OUT_BITS-1:0] bitangent_x,
  output logic signed [OUT_BITS-1:0] bitangent_y,
  output logic signed [OUT_BITS-1:0] bitangent_z,
  output logic [1:0] corner_index,
  output logic last_of_triangle
);
  localparam int EW = (COORD_BITS + 1 > 25) ? 25 : COORD_BITS + 1;
  localparam int DW = (UV_BITS + 1 > 25) ? 25 : UV_BITS + 1;
  localparam int JW = 6 * EW + 4 * DW;

  logic push, pop, full, not_empty;
  logic [JW-1:0] job_in, job_out;

  ttb_front #(.COORD_BITS(COORD_BITS), .UV_BITS(UV_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready,
    .pos_x, .pos_y, .pos_z, .tex_u, .tex_v, .start_of_mesh,
    .full, .push, .job(job_in)
  );

  ttb_queue #(.WIDTH(JW)) u_queue (
    .clk, .rst, .push, .din(job_in), .pop, .dout(job_out), .not_empty, .full
  );

  ttb_back #(.COORD_BITS(COORD_BITS), .UV_BITS(UV_BITS), .OUT_BITS(OUT_BITS)) u_back (
    .clk, .rst, .job_valid(not_empty), .job(job_out), .pop,
    .out_valid, .out_ready,
    .tangent_x, .tangent_y, .tangent_z,
    .bitangent_x, .bitangent_y, .bitangent_z,
    .corner_index, .last_of_triangle
  );

  `TTB_ASSERT_NOW(a_no_push_when_full, push, !full, "request pushed into a full queue")
  `TTB_ASSERT_NOW(a_pop_needs_entry, pop, not_empty, "back end popped an empty queue")
  `TTB_ASSERT_NEXT(a_corners_stay, out_valid && out_ready && !last_of_triangle,
                   out_valid, "triangle results broken off")
endmodule
`default_nettype wire
